// File: rtl/core/dtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types, character codes and float constants for the decimal text to
// binary32 converter.
// ----------------------------------------------------------------------------
package dtb_pkg;

  localparam int COUNT_SAT_DEF   = 16383;
  localparam int SCALE_CLAMP_DEF = 255;

  // exponent width used inside the arithmetic unit (signed)
  localparam int EXP_W = 10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  localparam logic [31:0] F32_ZERO = 32'h0000_0000;
  localparam logic [31:0] F32_INF  = 32'h7F80_0000;

  // significand of the binary64 constant 0.1; value is P1_SIG * 2^-56
  localparam logic [52:0] P1_SIG = 53'h1999999999999A;

  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_EXPSTART,
    PH_EXPDIG,
    PH_IGNORE
  } phase_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_DIGIT,
    TS_SCALE,
    TS_SWAIT,
    TS_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_NORM,
    FS_MUL0,
    FS_MUL1,
    FS_ALIGN,
    FS_RND53,
    FS_RND24,
    FS_DONE
  } fpu_state_t;

  // MAC10: a*10 + digit; MULP1: a * 0.1 (binary64 constant)
  typedef enum logic {
    FOP_MAC10,
    FOP_MULP1
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [31:0] a;
    logic [3:0]  digit;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

  function automatic logic [31:0] digit_to_f32(input logic [3:0] d);
    logic [31:0] r;
    case (d)
      4'd1:    r = 32'h3F80_0000;
      4'd2:    r = 32'h4000_0000;
      4'd3:    r = 32'h4040_0000;
      4'd4:    r = 32'h4080_0000;
      4'd5:    r = 32'h40A0_0000;
      4'd6:    r = 32'h40C0_0000;
      4'd7:    r = 32'h40E0_0000;
      4'd8:    r = 32'h4100_0000;
      4'd9:    r = 32'h4110_0000;
      default: r = F32_ZERO;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/dtb_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_fpu
// Shared multi-cycle float unit: a*10+digit or a*0.1, formed exactly, rounded
// to binary64 and then to binary32 (subnormals, overflow to infinity).
// ----------------------------------------------------------------------------
module dtb_fpu import dtb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  localparam int W_W  = 97;
  localparam int DV_W = 137;

  localparam logic signed [EXP_W-1:0] EA_SUB     = EXP_W'(-149);
  localparam logic signed [EXP_W-1:0] EA_BIAS    = EXP_W'(150);
  localparam logic signed [EXP_W-1:0] DV_OFS     = EXP_W'(108);
  localparam logic signed [EXP_W-1:0] MAC_OFS    = EXP_W'(68);
  localparam logic signed [EXP_W-1:0] P1_OFS     = EXP_W'(76);
  localparam logic signed [EXP_W-1:0] X_MIN_NORM = EXP_W'(-126);
  localparam logic signed [EXP_W-1:0] X_BIAS     = EXP_W'(127);
  localparam logic signed [EXP_W-1:0] X_EMAX     = EXP_W'(255);
  localparam logic signed [EXP_W-1:0] SUB_OFS    = EXP_W'(-97);
  localparam logic signed [EXP_W-1:0] SH_MAX     = EXP_W'(63);

  fpu_state_t state, state_next;

  fop_t                     op;
  logic [23:0]              m;
  logic signed [EXP_W-1:0]  ea;
  logic [3:0]               dig;
  logic [50:0]              mhi;
  logic [50:0]              mlo;
  logic [W_W-1:0]           w;
  logic                     wst;
  logic signed [EXP_W-1:0]  bexp;
  logic [52:0]              dsig;
  logic signed [EXP_W-1:0]  xexp;
  logic [31:0]              res;

  // operand decode
  logic [7:0]  a_exp;
  logic [22:0] a_frac;
  assign a_exp  = req.a[30:23];
  assign a_frac = req.a[22:0];

  // shared multiplier
  logic [26:0] mul_b;
  logic [50:0] mul_p;
  always_comb begin
    if (state == FS_MUL1) begin
      mul_b = {1'b0, P1_SIG[25:0]};
    end else if (op == FOP_MULP1) begin
      mul_b = P1_SIG[52:26];
    end else begin
      mul_b = 27'd10;
    end
  end
  assign mul_p = {27'b0, m} * {24'b0, mul_b};

  // alignment of the digit against the product
  logic signed [EXP_W-1:0] dv_amt_s;
  logic [DV_W-1:0]         dvec;
  logic [W_W-1:0]          w_mac;
  logic [76:0]             prod;
  assign dv_amt_s = DV_OFS - ea;
  assign dvec     = {{(DV_W-4){1'b0}}, dig} << dv_amt_s[8:0];
  assign w_mac    = {1'b0, mhi[27:0], 68'b0} + dvec[DV_W-1:40];
  assign prod     = {mhi, 26'b0} + {26'b0, mlo};

  // round to binary64
  logic [W_W-1:0]          wn;
  logic signed [EXP_W-1:0] lead;
  logic [53:0]             sum54;
  logic                    up53;
  always_comb begin
    if (w[96]) begin
      wn   = w;
      lead = EXP_W'(96);
    end else if (w[95]) begin
      wn   = {w[95:0], 1'b0};
      lead = EXP_W'(95);
    end else begin
      wn   = {w[94:0], 2'b0};
      lead = EXP_W'(94);
    end
    up53  = wn[43] & ((|wn[42:0]) | wst | wn[44]);
    sum54 = {1'b0, wn[96:44]} + 54'(up53);
  end

  // round to binary32
  logic signed [EXP_W-1:0] expf;
  logic signed [EXP_W-1:0] sh_s;
  logic [5:0]              sh;
  logic [116:0]            dx;
  logic                    up24;
  logic [31:0]             res24;
  always_comb begin
    expf  = xexp + X_BIAS;
    sh_s  = SUB_OFS - xexp;
    sh    = (sh_s > SH_MAX) ? 6'd63 : sh_s[5:0];
    dx    = {dsig, 64'b0} >> sh;
    up24  = 1'b0;
    res24 = F32_ZERO;
    if (xexp >= X_MIN_NORM) begin
      if (expf >= X_EMAX) begin
        res24 = F32_INF;
      end else begin
        up24  = dsig[28] & ((|dsig[27:0]) | dsig[29]);
        res24 = {1'b0, expf[7:0], dsig[51:29]} + 32'(up24);
      end
    end else begin
      // carry out of the fraction lands in the exponent field as min normal
      up24  = dx[63] & ((|dx[62:0]) | dx[64]);
      res24 = {9'b0, dx[86:64]} + 32'(up24);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rsp.done   = 1'b0;
    rsp.res    = res;
    case (state)
      FS_IDLE: begin
        if (req.start) begin
          if (a_exp == 8'hFF || (a_exp == 8'h00 && a_frac == 23'd0)) begin
            state_next = FS_DONE;
          end else if (a_exp == 8'h00) begin
            state_next = FS_NORM;
          end else begin
            state_next = FS_MUL0;
          end
        end
      end
      FS_NORM: begin
        if (m[23]) begin
          state_next = FS_MUL0;
        end
      end
      FS_MUL0:  state_next = (op == FOP_MULP1) ? FS_MUL1 : FS_ALIGN;
      FS_MUL1:  state_next = FS_ALIGN;
      FS_ALIGN: state_next = FS_RND53;
      FS_RND53: state_next = FS_RND24;
      FS_RND24: state_next = FS_DONE;
      FS_DONE: begin
        rsp.done   = 1'b1;
        state_next = FS_IDLE;
      end
      default:  state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      FS_IDLE: begin
        op  <= req.op;
        dig <= req.digit;
        if (a_exp == 8'hFF) begin
          res <= F32_INF;
        end else if (a_exp == 8'h00 && a_frac == 23'd0) begin
          res <= (req.op == FOP_MAC10) ? digit_to_f32(req.digit) : F32_ZERO;
        end
        if (a_exp == 8'h00) begin
          m  <= {1'b0, a_frac};
          ea <= EA_SUB;
        end else begin
          m  <= {1'b1, a_frac};
          ea <= EXP_W'({2'b0, a_exp}) - EA_BIAS;
        end
      end
      FS_NORM: begin
        // shift a subnormal up to a leading one
        if (!m[23]) begin
          m  <= {m[22:0], 1'b0};
          ea <= ea - EXP_W'(1);
        end
      end
      FS_MUL0: mhi <= mul_p;
      FS_MUL1: mlo <= mul_p;
      FS_ALIGN: begin
        if (op == FOP_MULP1) begin
          w    <= {prod, 20'b0};
          wst  <= 1'b0;
          bexp <= ea - P1_OFS;
        end else begin
          w    <= w_mac;
          wst  <= |dvec[39:0];
          bexp <= ea - MAC_OFS;
        end
      end
      FS_RND53: begin
        if (sum54[53]) begin
          dsig <= sum54[53:1];
          xexp <= bexp + lead + EXP_W'(1);
        end else begin
          dsig <= sum54[52:0];
          xexp <= bexp + lead;
        end
      end
      FS_RND24: res <= res24;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/decimal_text_to_binary32_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_binary32_core
// Parses a NUL-terminated decimal string, one character per transfer, and
// returns the binary32 bit pattern of the number.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  input     | ch_valid / ch_ready       | ch [7:0]
//  output    | value_valid / value_ready | value_bits [31:0]
//
//  A non-digit character needs no float unit pass. A digit takes the transfer
//  plus one pass through the shared float unit (normalize a subnormal,
//  multiply, align, two rounding steps, done; zero goes straight to done).
//  The NUL takes one unit pass per scale step, a times-0.1 step with a second
//  multiply, up to SCALE_CLAMP steps, ending early at a zero or infinite value.
//  Synchronous reset returns the parser to the start of a string.
//  A result waiting on value_ready holds the next NUL at its emit step.
// ----------------------------------------------------------------------------
module decimal_text_to_binary32_core import dtb_pkg::*; #(
  parameter int COUNT_SAT   = COUNT_SAT_DEF,
  parameter int SCALE_CLAMP = SCALE_CLAMP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ch_valid,
  output logic        ch_ready,
  input  logic [7:0]  ch,
  output logic        value_valid,
  input  logic        value_ready,
  output logic [31:0] value_bits
);

  localparam int CW  = $clog2(COUNT_SAT + 1);
  localparam int SW  = $clog2(SCALE_CLAMP + 1);
  localparam int SDW = ((CW > SW) ? CW : SW) + 2;
  localparam logic [CW-1:0]         CNT_MAX = CW'(COUNT_SAT);
  localparam logic signed [SDW-1:0] S_HI    = SDW'(SCALE_CLAMP);
  localparam logic signed [SDW-1:0] S_LO    = SDW'(-SCALE_CLAMP);

  top_state_t    state, state_next;
  phase_t        phase, phase_next;
  logic [31:0]   acc, acc_next;
  logic          negative, negative_next;
  logic [CW-1:0] frac_cnt, frac_cnt_next;
  logic [CW-1:0] exp_dig, exp_dig_next;
  logic          exp_neg, exp_neg_next;
  logic          scale_neg, scale_neg_next;
  logic [SW-1:0] scale_cnt, scale_cnt_next;
  logic          value_valid_next;
  logic [31:0]   value_bits_next;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  dtb_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  logic            accept;
  logic            is_dig;
  logic [3:0]      dval;
  logic [CW+3:0]   exp_v;
  logic [CW-1:0]   exp_sat;
  logic signed [SDW-1:0] s_exp, s_raw, s_cl, s_mag;

  assign accept = ch_valid & ch_ready;
  assign is_dig = ch inside {[8'h30:8'h39]};
  assign dval   = ch[3:0];

  always_comb begin
    exp_v   = ({4'b0, exp_dig} << 3) + ({4'b0, exp_dig} << 1) + (CW+4)'(dval);
    exp_sat = (exp_v > (CW+4)'(COUNT_SAT)) ? CNT_MAX : exp_v[CW-1:0];
    s_exp   = $signed(SDW'(exp_dig));
    if (exp_neg) begin
      s_exp = -s_exp;
    end
    s_raw = s_exp - $signed(SDW'(frac_cnt));
    if (s_raw > S_HI) begin
      s_cl = S_HI;
    end else if (s_raw < S_LO) begin
      s_cl = S_LO;
    end else begin
      s_cl = s_raw;
    end
    s_mag = (s_cl < 0) ? -s_cl : s_cl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= TS_IDLE;
      phase       <= PH_START;
      acc         <= F32_ZERO;
      negative    <= 1'b0;
      frac_cnt    <= '0;
      exp_dig     <= '0;
      exp_neg     <= 1'b0;
      scale_neg   <= 1'b0;
      scale_cnt   <= '0;
      value_valid <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      acc         <= acc_next;
      negative    <= negative_next;
      frac_cnt    <= frac_cnt_next;
      exp_dig     <= exp_dig_next;
      exp_neg     <= exp_neg_next;
      scale_neg   <= scale_neg_next;
      scale_cnt   <= scale_cnt_next;
      value_valid <= value_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value_bits <= value_bits_next;
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    acc_next         = acc;
    negative_next    = negative;
    frac_cnt_next    = frac_cnt;
    exp_dig_next     = exp_dig;
    exp_neg_next     = exp_neg;
    scale_neg_next   = scale_neg;
    scale_cnt_next   = scale_cnt;
    value_bits_next  = value_bits;
    value_valid_next = value_valid & ~value_ready;
    ch_ready         = 1'b0;
    fpu_req.start    = 1'b0;
    fpu_req.op       = FOP_MAC10;
    fpu_req.a        = acc;
    fpu_req.digit    = dval;

    case (state)
      TS_IDLE: begin
        ch_ready = 1'b1;
        if (accept) begin
          if (ch == CH_NUL) begin
            scale_neg_next = (s_cl < 0);
            scale_cnt_next = s_mag[SW-1:0];
            state_next     = TS_SCALE;
          end else begin
            case (phase)
              PH_START, PH_INT: begin
                if (phase == PH_START && ch == CH_MINUS) begin
                  negative_next = 1'b1;
                  phase_next    = PH_INT;
                end else if (is_dig) begin
                  fpu_req.start = 1'b1;
                  phase_next    = PH_INT;
                  state_next    = TS_DIGIT;
                end else if (ch == CH_DOT) begin
                  phase_next = PH_FRAC;
                end else if (ch == CH_E_LO || ch == CH_E_UP) begin
                  phase_next = PH_EXPSTART;
                end else begin
                  phase_next = PH_IGNORE;
                end
              end
              PH_FRAC: begin
                if (is_dig) begin
                  fpu_req.start = 1'b1;
                  state_next    = TS_DIGIT;
                  if (frac_cnt < CNT_MAX) begin
                    frac_cnt_next = frac_cnt + CW'(1);
                  end
                end else if (ch == CH_E_LO || ch == CH_E_UP) begin
                  phase_next = PH_EXPSTART;
                end else begin
                  phase_next = PH_IGNORE;
                end
              end
              PH_EXPSTART: begin
                if (ch == CH_PLUS) begin
                  phase_next = PH_EXPDIG;
                end else if (ch == CH_MINUS) begin
                  exp_neg_next = 1'b1;
                  phase_next   = PH_EXPDIG;
                end else if (is_dig) begin
                  exp_dig_next = exp_sat;
                  phase_next   = PH_EXPDIG;
                end else begin
                  phase_next = PH_IGNORE;
                end
              end
              PH_EXPDIG: begin
                if (is_dig) begin
                  exp_dig_next = exp_sat;
                end else begin
                  phase_next = PH_IGNORE;
                end
              end
              default: phase_next = PH_IGNORE;
            endcase
          end
        end
      end
      TS_DIGIT: begin
        if (fpu_rsp.done) begin
          acc_next   = fpu_rsp.res;
          state_next = TS_IDLE;
        end
      end
      TS_SCALE: begin
        // zero and infinity are fixed points of both scale steps
        if (scale_cnt == '0 || acc == F32_ZERO || acc[30:23] == 8'hFF) begin
          state_next = TS_EMIT;
        end else begin
          fpu_req.start  = 1'b1;
          fpu_req.op     = scale_neg ? FOP_MULP1 : FOP_MAC10;
          fpu_req.digit  = 4'd0;
          scale_cnt_next = scale_cnt - SW'(1);
          state_next     = TS_SWAIT;
        end
      end
      TS_SWAIT: begin
        if (fpu_rsp.done) begin
          acc_next   = fpu_rsp.res;
          state_next = TS_SCALE;
        end
      end
      TS_EMIT: begin
        if (!value_valid || value_ready) begin
          value_bits_next  = acc ^ {negative, 31'b0};
          value_valid_next = 1'b1;
          phase_next       = PH_START;
          acc_next         = F32_ZERO;
          negative_next    = 1'b0;
          frac_cnt_next    = '0;
          exp_dig_next     = '0;
          exp_neg_next     = 1'b0;
          state_next       = TS_IDLE;
        end
      end
      default: state_next = TS_IDLE;
    endcase
  end

endmodule

// File: rtl/core/dtb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks for the decimal text to binary32 converter.
// ----------------------------------------------------------------------------
module dtb_checker import dtb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        ch_valid,
  input logic        ch_ready,
  input logic [7:0]  ch,
  input logic        value_valid,
  input logic        value_ready,
  input logic [31:0] value_bits
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    value_valid && !value_ready |=> value_valid && $stable(value_bits))
    else $error("result changed while stalled");

  // the terminator starts the scaling pass, so input stalls next cycle
  a_nul_busy: assert property (@(posedge clk) disable iff (rst)
    ch_valid && ch_ready && ch == CH_NUL |=> !ch_ready)
    else $error("input taken right after terminator");

  // a new result only appears after the block stopped taking input
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(value_valid) |-> $past(!ch_ready))
    else $error("result appeared without a scaling pass");

  a_reset: assert property (@(posedge clk)
    rst |=> !value_valid && ch_ready)
    else $error("reset state wrong");

endmodule

bind decimal_text_to_binary32_core dtb_checker u_dtb_checker (.*);
